FILE: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCTU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define MCTU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mctu_pkg.sv
package mctu_pkg;

   localparam int MAX_TOUCHES  = 16;
   localparam int COORD_BITS   = 16;
   localparam int ACC_BITS     = COORD_BITS + 2;
   localparam int AXES         = 3;
   localparam int ACTION_BITS  = 2;
   localparam int ID_BITS      = 4;
   localparam int STATUS_BITS  = 2;
   localparam int PCOUNT_BITS  = 5;
   localparam int IDX_BITS     = $clog2(MAX_TOUCHES);
   localparam int CNT_BITS     = $clog2(MAX_TOUCHES + 1);
   localparam int SUM_BITS     = COORD_BITS + CNT_BITS;
   localparam int REM_BITS     = CNT_BITS + 1;
   localparam int STEP_BITS    = $clog2(COORD_BITS + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;
   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef coord_type [AXES-1:0]         point_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_DOWN = 2'd0,
      ACT_MOVE = 2'd1,
      ACT_UP   = 2'd2,
      ACT_BAD  = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_DUP     = 2'd2,
      ST_BAD     = 2'd3
   } status_type;

   // clamp a one-bit-wider sum into the accumulator range
   function automatic acc_type sat_acc(input logic signed [ACC_BITS:0] v);
      acc_type r;
      if (v[ACC_BITS] != v[ACC_BITS-1]) begin
         r = v[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
         r = v[ACC_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/mctu_req_if.sv
interface mctu_req_if;
   logic                                valid;
   logic                                ready;
   logic [mctu_pkg::ACTION_BITS-1:0]    action;
   logic [mctu_pkg::ID_BITS-1:0]        touch_id;
   mctu_pkg::coord_type                 pos_x;
   mctu_pkg::coord_type                 pos_y;
   mctu_pkg::coord_type                 pos_z;

   modport source (output valid, action, touch_id, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, action, touch_id, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: src/mctu_rsp_if.sv
interface mctu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mctu_pkg::STATUS_BITS-1:0]    status;
   logic [mctu_pkg::ID_BITS-1:0]        echo_id;
   logic [mctu_pkg::PCOUNT_BITS-1:0]    point_count;
   mctu_pkg::coord_type                 centroid_x;
   mctu_pkg::coord_type                 centroid_y;
   mctu_pkg::coord_type                 centroid_z;
   mctu_pkg::acc_type                   origin_x;
   mctu_pkg::acc_type                   origin_y;
   mctu_pkg::acc_type                   origin_z;
   mctu_pkg::acc_type                   shift_x;
   mctu_pkg::acc_type                   shift_y;
   mctu_pkg::acc_type                   shift_z;

   modport source (output valid, status, echo_id, point_count,
                   centroid_x, centroid_y, centroid_z,
                   origin_x, origin_y, origin_z,
                   shift_x, shift_y, shift_z,
                   input ready);
   modport sink   (input valid, status, echo_id, point_count,
                   centroid_x, centroid_y, centroid_z,
                   origin_x, origin_y, origin_z,
                   shift_x, shift_y, shift_z,
                   output ready);
endinterface

FILE: src/mctu_store.sv
// per-id stored position, one write and one registered read port
module mctu_store (
   input  logic                clock,
   input  logic                wr_en,
   input  mctu_pkg::idx_type   wr_addr,
   input  mctu_pkg::point_type wr_data,
   input  logic                rd_en,
   input  mctu_pkg::idx_type   rd_addr,
   output mctu_pkg::point_type rd_data
);

   mctu_pkg::point_type mem_ff [mctu_pkg::MAX_TOUCHES];
   mctu_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mctu_div.sv
// signed sum / unsigned count, truncating toward zero, one quotient bit per cycle
module mctu_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mctu_pkg::sum_type   dividend,
   input  mctu_pkg::cnt_type   divisor,
   output logic                done,
   output mctu_pkg::coord_type quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [mctu_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic [mctu_pkg::REM_BITS-1:0]      rem_ff, rem_in;
   logic [mctu_pkg::COORD_BITS-1:0]    lo_ff, lo_in;
   mctu_pkg::cnt_type                  div_ff, div_in;
   logic                               neg_ff, neg_in;

   logic [mctu_pkg::SUM_BITS-1:0]      mag;
   logic [mctu_pkg::REM_BITS-1:0]      trial;
   logic                               ge;

   always_comb begin
      mag   = dividend[mctu_pkg::SUM_BITS-1] ? mctu_pkg::SUM_BITS'(-dividend) : dividend;
      trial = {rem_ff[mctu_pkg::REM_BITS-2:0], lo_ff[mctu_pkg::COORD_BITS-1]};
      ge    = trial >= mctu_pkg::REM_BITS'(div_ff);

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;

      if (start) begin
         // high quotient bits are known zero since |sum| <= count * 2^(COORD_BITS-1)
         busy_in = 1'b1;
         step_in = mctu_pkg::STEP_BITS'(mctu_pkg::COORD_BITS);
         rem_in  = mctu_pkg::REM_BITS'(mag >> mctu_pkg::COORD_BITS);
         lo_in   = mag[mctu_pkg::COORD_BITS-1:0];
         div_in  = divisor;
         neg_in  = dividend[mctu_pkg::SUM_BITS-1];
      end else if (busy_ff) begin
         rem_in  = ge ? trial - mctu_pkg::REM_BITS'(div_ff) : trial;
         lo_in   = {lo_ff[mctu_pkg::COORD_BITS-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == mctu_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? mctu_pkg::coord_type'(~lo_ff + 1'b1) : mctu_pkg::coord_type'(lo_ff);

endmodule

FILE: src/multitouch_centroid_tracker_unit.sv
// Multitouch centroid tracker. Takes down, move and up events per touch id and answers each
// with exactly one result transaction: a status code, the id, the number of points down, the
// centroid (coordinate sums divided by the count, truncated toward zero), the original
// centroid moved by motion only, and the offset collected from downs and ups; the last two
// saturate to COORD_BITS+2 bits and everything clears when the last point lifts. An accepted
// event that updates the centroid passes S_LOOKUP, then S_DIV_ISSUE and S_DIV_WAIT once per
// axis on the single bit-serial divider, then S_EMIT; a rejected event or the last up goes
// from S_LOOKUP straight to S_EMIT. The input stays not ready until the result is loaded
// into the output register. Stored positions of ids never touched down are never used, so
// the point store needs no clearing after reset.
module multitouch_centroid_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   mctu_req_if.sink    req_bus,
   mctu_rsp_if.source  rsp_bus
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_DIV_ISSUE,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   // control and architectural state
   state_type                          state_ff, state_in;
   logic [1:0]                         axis_ff, axis_in;
   logic [mctu_pkg::MAX_TOUCHES-1:0]   valid_ff, valid_in;
   mctu_pkg::cnt_type                  count_ff, count_in;
   mctu_pkg::sum_type                  sum_ff [mctu_pkg::AXES];
   mctu_pkg::sum_type                  sum_in [mctu_pkg::AXES];
   mctu_pkg::coord_type                cent_ff [mctu_pkg::AXES];
   mctu_pkg::coord_type                cent_in [mctu_pkg::AXES];
   mctu_pkg::acc_type                  origin_ff [mctu_pkg::AXES];
   mctu_pkg::acc_type                  origin_in [mctu_pkg::AXES];
   mctu_pkg::acc_type                  offset_ff [mctu_pkg::AXES];
   mctu_pkg::acc_type                  offset_in [mctu_pkg::AXES];
   logic                               rsp_valid_ff, rsp_valid_in;

   // captured event and result payload
   mctu_pkg::action_type               action_ff, action_in;
   logic [mctu_pkg::ID_BITS-1:0]       id_ff, id_in;
   mctu_pkg::point_type                pos_ff, pos_in;
   mctu_pkg::status_type               status_ff, status_in;
   mctu_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [mctu_pkg::ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic [mctu_pkg::PCOUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   mctu_pkg::coord_type                rsp_cent_ff [mctu_pkg::AXES];
   mctu_pkg::coord_type                rsp_cent_in [mctu_pkg::AXES];
   mctu_pkg::acc_type                  rsp_origin_ff [mctu_pkg::AXES];
   mctu_pkg::acc_type                  rsp_origin_in [mctu_pkg::AXES];
   mctu_pkg::acc_type                  rsp_shift_ff [mctu_pkg::AXES];
   mctu_pkg::acc_type                  rsp_shift_in [mctu_pkg::AXES];

   // point store and divider hookup
   logic                               req_take;
   logic                               st_wr_en;
   mctu_pkg::idx_type                  id_idx;
   mctu_pkg::point_type                st_rd_data;
   logic                               div_start;
   logic                               div_done;
   mctu_pkg::coord_type                div_quot;

   // per-event decode and shared saturating adder
   logic                               id_out_of_range;
   logic                               id_hit;
   logic                               add_pos, sub_stored;
   logic signed [mctu_pkg::COORD_BITS:0] delta;
   mctu_pkg::acc_type                  acc_pick;
   logic signed [mctu_pkg::ACC_BITS:0] acc_sum;
   mctu_pkg::acc_type                  acc_sat;

   assign req_take = req_bus.valid && req_bus.ready;
   assign id_idx   = mctu_pkg::IDX_BITS'(id_ff);

   mctu_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (id_idx),
      .wr_data (pos_ff),
      .rd_en   (req_take),
      .rd_addr (mctu_pkg::IDX_BITS'(req_bus.touch_id)),
      .rd_data (st_rd_data)
   );

   mctu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[axis_ff]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      cent_in       = cent_ff;
      origin_in     = origin_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      action_in     = action_ff;
      id_in         = id_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_cent_in   = rsp_cent_ff;
      rsp_origin_in = rsp_origin_ff;
      rsp_shift_in  = rsp_shift_ff;
      st_wr_en      = 1'b0;
      div_start     = 1'b0;
      add_pos       = 1'b0;
      sub_stored    = 1'b0;

      id_out_of_range = 32'(id_ff) >= mctu_pkg::MAX_TOUCHES;
      id_hit          = !id_out_of_range && valid_ff[id_idx];

      // centroid change on this axis, folded into origin for moves, offset otherwise
      delta    = (mctu_pkg::COORD_BITS+1)'(div_quot) - (mctu_pkg::COORD_BITS+1)'(cent_ff[axis_ff]);
      acc_pick = (action_ff == mctu_pkg::ACT_MOVE) ? origin_ff[axis_ff] : offset_ff[axis_ff];
      acc_sum  = (mctu_pkg::ACC_BITS+1)'(acc_pick) + (mctu_pkg::ACC_BITS+1)'(delta);
      acc_sat  = mctu_pkg::sat_acc(acc_sum);

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               action_in = mctu_pkg::action_type'(req_bus.action);
               id_in     = req_bus.touch_id;
               pos_in[0] = req_bus.pos_x;
               pos_in[1] = req_bus.pos_y;
               pos_in[2] = req_bus.pos_z;
               state_in  = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            status_in = mctu_pkg::ST_OK;
            axis_in   = 2'd0;
            state_in  = S_DIV_ISSUE;
            if (action_ff == mctu_pkg::ACT_BAD) begin
               status_in = mctu_pkg::ST_BAD;
               state_in  = S_EMIT;
            end else if (id_out_of_range) begin
               status_in = mctu_pkg::ST_UNKNOWN;
               state_in  = S_EMIT;
            end else if (action_ff == mctu_pkg::ACT_DOWN) begin
               if (id_hit) begin
                  status_in = mctu_pkg::ST_DUP;
                  state_in  = S_EMIT;
               end else begin
                  valid_in[id_idx] = 1'b1;
                  count_in         = count_ff + 1'b1;
                  add_pos          = 1'b1;
                  st_wr_en         = 1'b1;
               end
            end else if (!id_hit) begin
               status_in = mctu_pkg::ST_UNKNOWN;
               state_in  = S_EMIT;
            end else if (action_ff == mctu_pkg::ACT_MOVE) begin
               add_pos    = 1'b1;
               sub_stored = 1'b1;
               st_wr_en   = 1'b1;
            end else begin
               valid_in[id_idx] = 1'b0;
               count_in         = count_ff - 1'b1;
               sub_stored       = 1'b1;
               if (count_ff == mctu_pkg::CNT_BITS'(1)) begin
                  // last point lifted: everything returns to zero
                  sub_stored = 1'b0;
                  for (int k = 0; k < mctu_pkg::AXES; k++) begin
                     sum_in[k]    = '0;
                     cent_in[k]   = '0;
                     origin_in[k] = '0;
                     offset_in[k] = '0;
                  end
                  state_in = S_EMIT;
               end
            end
            if (add_pos || sub_stored) begin
               for (int k = 0; k < mctu_pkg::AXES; k++) begin
                  sum_in[k] = sum_ff[k]
                     + (add_pos    ? mctu_pkg::SUM_BITS'($signed(pos_ff[k]))     : '0)
                     - (sub_stored ? mctu_pkg::SUM_BITS'($signed(st_rd_data[k])) : '0);
               end
            end
         end
         S_DIV_ISSUE: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               cent_in[axis_ff] = div_quot;
               if (action_ff == mctu_pkg::ACT_DOWN && count_ff == mctu_pkg::CNT_BITS'(1)) begin
                  // first point down sets the original centroid
                  origin_in[axis_ff] = mctu_pkg::ACC_BITS'(div_quot);
               end else if (action_ff == mctu_pkg::ACT_MOVE) begin
                  origin_in[axis_ff] = acc_sat;
               end else begin
                  offset_in[axis_ff] = acc_sat;
               end
               if (axis_ff == 2'(mctu_pkg::AXES - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_DIV_ISSUE;
               end
            end
         end
         S_EMIT: begin
            // load the output register once it is free or being taken
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = id_ff;
               rsp_count_in  = mctu_pkg::PCOUNT_BITS'(count_ff);
               rsp_cent_in   = cent_ff;
               rsp_origin_in = origin_ff;
               rsp_shift_in  = offset_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 2'd0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < mctu_pkg::AXES; k++) begin
            sum_ff[k]    <= '0;
            cent_ff[k]   <= '0;
            origin_ff[k] <= '0;
            offset_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         cent_ff      <= cent_in;
         origin_ff    <= origin_in;
         offset_ff    <= offset_in;
      end
      // payload, no reset
      action_ff     <= action_in;
      id_ff         <= id_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_cent_ff   <= rsp_cent_in;
      rsp_origin_ff <= rsp_origin_in;
      rsp_shift_ff  <= rsp_shift_in;
   end

   // ports
   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.echo_id     = rsp_id_ff;
   assign rsp_bus.point_count = rsp_count_ff;
   assign rsp_bus.centroid_x  = rsp_cent_ff[0];
   assign rsp_bus.centroid_y  = rsp_cent_ff[1];
   assign rsp_bus.centroid_z  = rsp_cent_ff[2];
   assign rsp_bus.origin_x    = rsp_origin_ff[0];
   assign rsp_bus.origin_y    = rsp_origin_ff[1];
   assign rsp_bus.origin_z    = rsp_origin_ff[2];
   assign rsp_bus.shift_x     = rsp_shift_ff[0];
   assign rsp_bus.shift_y     = rsp_shift_ff[1];
   assign rsp_bus.shift_z     = rsp_shift_ff[2];

endmodule

FILE: src/mctu_checker.sv
`include "assert_macros.svh"

module mctu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mctu_pkg::STATUS_BITS-1:0]  rsp_status,
   input logic [mctu_pkg::PCOUNT_BITS-1:0]  rsp_point_count,
   input mctu_pkg::coord_type               rsp_centroid_x,
   input mctu_pkg::coord_type               rsp_centroid_y,
   input mctu_pkg::coord_type               rsp_centroid_z,
   input mctu_pkg::acc_type                 rsp_origin_x,
   input mctu_pkg::acc_type                 rsp_origin_y,
   input mctu_pkg::acc_type                 rsp_origin_z,
   input mctu_pkg::acc_type                 rsp_shift_x,
   input mctu_pkg::acc_type                 rsp_shift_y,
   input mctu_pkg::acc_type                 rsp_shift_z
);

   // a stalled result stays valid and holds its status, count, centroid_x, origin_y and shift_z
   `MCTU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_point_count) && $stable(rsp_centroid_x) && $stable(rsp_origin_y) && $stable(rsp_shift_z), "stalled result changed")

   // one event at a time: no new transaction right after one is taken
   `MCTU_ASSERT_NEXT(a_one_event, req_valid && req_ready, !req_ready, "input ready right after an accept")

   // count never exceeds the point store
   `MCTU_ASSERT_SAME(a_count_max, rsp_valid, rsp_point_count <= mctu_pkg::PCOUNT_BITS'(mctu_pkg::MAX_TOUCHES), "point count above store depth")

   // with no points down every tracked value is zero
   `MCTU_ASSERT_SAME(a_empty_zero, rsp_valid && rsp_point_count == '0, rsp_centroid_x == '0 && rsp_centroid_y == '0 && rsp_centroid_z == '0 && rsp_origin_x == '0 && rsp_origin_y == '0 && rsp_origin_z == '0 && rsp_shift_x == '0 && rsp_shift_y == '0 && rsp_shift_z == '0, "nonzero values with no points down")

endmodule

bind multitouch_centroid_tracker_unit mctu_checker u_mctu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_point_count (rsp_bus.point_count),
   .rsp_centroid_x  (rsp_bus.centroid_x),
   .rsp_centroid_y  (rsp_bus.centroid_y),
   .rsp_centroid_z  (rsp_bus.centroid_z),
   .rsp_origin_x    (rsp_bus.origin_x),
   .rsp_origin_y    (rsp_bus.origin_y),
   .rsp_origin_z    (rsp_bus.origin_z),
   .rsp_shift_x     (rsp_bus.shift_x),
   .rsp_shift_y     (rsp_bus.shift_y),
   .rsp_shift_z     (rsp_bus.shift_z)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // run shape
   localparam int RANDOM_EVENTS = 1650;
   localparam int PHASE_LEN     = 150;
   // divider runs once per axis for each accepted update
   localparam int TAIL_CYCLES   = 3 * (mctu_pkg::COORD_BITS + 2) + 10;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int REPORT_MAX    = 10;

   localparam mctu_pkg::coord_type COORD_MAX = {1'b0, {(mctu_pkg::COORD_BITS-1){1'b1}}};
   localparam mctu_pkg::coord_type COORD_MIN = {1'b1, {(mctu_pkg::COORD_BITS-1){1'b0}}};
   localparam longint ACC_MAX = (longint'(1) <<< (mctu_pkg::ACC_BITS - 1)) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   // one touch event as the sender presents it
   typedef struct packed {
      mctu_pkg::action_type              act;
      logic [mctu_pkg::ID_BITS-1:0]      id;
      mctu_pkg::coord_type               x;
      mctu_pkg::coord_type               y;
      mctu_pkg::coord_type               z;
   } touch_event_type;

   // one expected result transaction
   typedef struct packed {
      mctu_pkg::status_type                       status;
      logic [mctu_pkg::ID_BITS-1:0]               id;
      logic [mctu_pkg::PCOUNT_BITS-1:0]           count;
      mctu_pkg::point_type                        centroid;
      mctu_pkg::acc_type [mctu_pkg::AXES-1:0]     origin;
      mctu_pkg::acc_type [mctu_pkg::AXES-1:0]     shift;
   } touch_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mctu_req_if req_bus ();
   mctu_rsp_if rsp_bus ();

   multitouch_centroid_tracker_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // events waiting for the driver, results waiting for the monitor
   touch_event_type  pending_events[$];
   touch_result_type centroid_expected[$];

   // shadow of the tracker used by the predictor
   bit     pt_down [mctu_pkg::MAX_TOUCHES];
   longint pt_pos  [mctu_pkg::MAX_TOUCHES][mctu_pkg::AXES];
   int     pt_count;
   longint pt_sum  [mctu_pkg::AXES];
   longint pt_cen  [mctu_pkg::AXES];
   longint pt_org  [mctu_pkg::AXES];
   longint pt_shf  [mctu_pkg::AXES];
   longint cen_delta [mctu_pkg::AXES];

   // ids the stimulus generator believes are down
   bit     gen_down [mctu_pkg::MAX_TOUCHES];
   int     gen_count;

   int     events_accepted;
   int     results_seen;
   int     directed_events;
   int     mismatch_count;
   int     idle_cycles;
   touch_event_type  next_event;
   touch_result_type got_expect;

   // ---------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------

   function automatic longint clamp_acc(input longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
   endfunction

   // centroid is sum / count truncated toward zero; keeps the per-axis change
   function automatic void update_centroid();
      longint c;
      for (int k = 0; k < mctu_pkg::AXES; k++) begin
         c = (pt_count != 0) ? pt_sum[k] / longint'(pt_count) : 0;
         cen_delta[k] = c - pt_cen[k];
         pt_cen[k] = c;
      end
   endfunction

   // apply one accepted event to the shadow and queue the result it must produce
   function automatic void track_touch_event(input mctu_pkg::action_type act,
                                             input logic [mctu_pkg::ID_BITS-1:0] id,
                                             input mctu_pkg::coord_type px,
                                             input mctu_pkg::coord_type py,
                                             input mctu_pkg::coord_type pz);
      longint               pos [mctu_pkg::AXES];
      mctu_pkg::status_type st;
      touch_result_type     r;
      pos[0] = px;
      pos[1] = py;
      pos[2] = pz;
      st = mctu_pkg::ST_OK;
      if (act == mctu_pkg::ACT_BAD) begin
         st = mctu_pkg::ST_BAD;
      end else if (int'(id) >= mctu_pkg::MAX_TOUCHES) begin
         st = mctu_pkg::ST_UNKNOWN;
      end else if (act == mctu_pkg::ACT_DOWN) begin
         if (pt_down[id]) begin
            st = mctu_pkg::ST_DUP;
         end else begin
            pt_down[id] = 1'b1;
            pt_count++;
            for (int k = 0; k < mctu_pkg::AXES; k++) begin
               pt_pos[id][k] = pos[k];
               pt_sum[k] += pos[k];
            end
            update_centroid();
            // first point fixes the origin, later ones move the offset
            for (int k = 0; k < mctu_pkg::AXES; k++) begin
               if (pt_count == 1) pt_org[k] = clamp_acc(pt_cen[k]);
               else pt_shf[k] = clamp_acc(pt_shf[k] + cen_delta[k]);
            end
         end
      end else if (!pt_down[id]) begin
         st = mctu_pkg::ST_UNKNOWN;
      end else if (act == mctu_pkg::ACT_MOVE) begin
         for (int k = 0; k < mctu_pkg::AXES; k++) begin
            pt_sum[k] += pos[k] - pt_pos[id][k];
            pt_pos[id][k] = pos[k];
         end
         update_centroid();
         for (int k = 0; k < mctu_pkg::AXES; k++) pt_org[k] = clamp_acc(pt_org[k] + cen_delta[k]);
      end else begin
         // up removes the stored position, not the event position
         pt_down[id] = 1'b0;
         if (pt_count != 0) pt_count--;
         for (int k = 0; k < mctu_pkg::AXES; k++) pt_sum[k] -= pt_pos[id][k];
         if (pt_count != 0) begin
            update_centroid();
            for (int k = 0; k < mctu_pkg::AXES; k++)
               pt_shf[k] = clamp_acc(pt_shf[k] + cen_delta[k]);
         end else begin
            // last point lifted: everything clears
            for (int k = 0; k < mctu_pkg::AXES; k++) begin
               pt_sum[k] = 0;
               pt_cen[k] = 0;
               pt_org[k] = 0;
               pt_shf[k] = 0;
            end
         end
      end
      r.status = st;
      r.id     = id;
      r.count  = pt_count[mctu_pkg::PCOUNT_BITS-1:0];
      for (int k = 0; k < mctu_pkg::AXES; k++) begin
         r.centroid[k] = pt_cen[k][mctu_pkg::COORD_BITS-1:0];
         r.origin[k]   = pt_org[k][mctu_pkg::ACC_BITS-1:0];
         r.shift[k]    = pt_shf[k][mctu_pkg::ACC_BITS-1:0];
      end
      centroid_expected.push_back(r);
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   // extremes, values near zero and full-range noise
   function automatic mctu_pkg::coord_type rand_coord();
      int s;
      s = $urandom_range(0, 64);
      case ($urandom_range(0, 7))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return mctu_pkg::coord_type'(s - 32);
         default: return mctu_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic void queue_event(input mctu_pkg::action_type act, input int id,
                                       input mctu_pkg::coord_type px,
                                       input mctu_pkg::coord_type py,
                                       input mctu_pkg::coord_type pz);
      touch_event_type e;
      e.act = act;
      e.id  = id[mctu_pkg::ID_BITS-1:0];
      e.x   = px;
      e.y   = py;
      e.z   = pz;
      pending_events.push_back(e);
      // keep the generator's view of which ids are down
      if (act == mctu_pkg::ACT_DOWN && !gen_down[e.id]) begin
         gen_down[e.id] = 1'b1;
         gen_count++;
      end else if (act == mctu_pkg::ACT_UP && gen_down[e.id]) begin
         gen_down[e.id] = 1'b0;
         gen_count--;
      end
   endfunction

   // random hold-off per side; phases rotate every PHASE_LEN transactions
   function automatic bit hold_off(input bit sender_side, input int done);
      int phase;
      int pct;
      phase = (done < directed_events) ? 0 : ((done - directed_events) / PHASE_LEN) % 4;
      case (phase)
         1:       pct = sender_side ? 67 : 0;
         2:       pct = sender_side ? 0 : 67;
         3:       pct = 8;
         default: pct = 0;
      endcase
      return $urandom_range(0, 99) < pct;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s: expected %0d, actual %0d", field, want, got);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // driver: presents queued events, holds each until the tracker takes it
   // ---------------------------------------------------------------------------------------

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.action   = mctu_pkg::ACT_DOWN;
      req_bus.touch_id = '0;
      req_bus.pos_x    = '0;
      req_bus.pos_y    = '0;
      req_bus.pos_z    = '0;
      rsp_bus.ready    = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         // transaction accepted at this edge: predict its result
         if (req_bus.valid && req_bus.ready) begin
            track_touch_event(mctu_pkg::action_type'(req_bus.action), req_bus.touch_id,
                              req_bus.pos_x, req_bus.pos_y, req_bus.pos_z);
            events_accepted++;
         end
         // slot is free: load the next event or go idle
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_events.size() > 0 && !hold_off(1'b1, events_accepted)) begin
               next_event = pending_events.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.action   <= next_event.act;
               req_bus.touch_id <= next_event.id;
               req_bus.pos_x    <= next_event.x;
               req_bus.pos_y    <= next_event.y;
               req_bus.pos_z    <= next_event.z;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: compares every result transaction against the oldest expectation
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (centroid_expected.size() == 0) begin
               // result with nothing waiting for it
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected result for id %0d", rsp_bus.echo_id);
            end else begin
               got_expect = centroid_expected.pop_front();
               check_field("status", got_expect.status, rsp_bus.status);
               check_field("echo_id", got_expect.id, rsp_bus.echo_id);
               check_field("point_count", got_expect.count, rsp_bus.point_count);
               check_field("centroid_x", got_expect.centroid[0], rsp_bus.centroid_x);
               check_field("centroid_y", got_expect.centroid[1], rsp_bus.centroid_y);
               check_field("centroid_z", got_expect.centroid[2], rsp_bus.centroid_z);
               check_field("origin_x", got_expect.origin[0], rsp_bus.origin_x);
               check_field("origin_y", got_expect.origin[1], rsp_bus.origin_y);
               check_field("origin_z", got_expect.origin[2], rsp_bus.origin_z);
               check_field("shift_x", got_expect.shift[0], rsp_bus.shift_x);
               check_field("shift_y", got_expect.shift[1], rsp_bus.shift_y);
               check_field("shift_z", got_expect.shift[2], rsp_bus.shift_z);
            end
         end
         rsp_bus.ready <= !hold_off(1'b0, results_seen);
      end
   end

   // ---------------------------------------------------------------------------------------
   // watchdog: cycles with no transaction on either channel
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------------

   initial begin
      int random_count;
      int roll;
      int down_pct;
      int up_pct;
      int pick;
      mctu_pkg::action_type act;

      // directed: rejections first, tracker empty
      queue_event(mctu_pkg::ACT_BAD, 15, COORD_MAX, COORD_MIN, COORD_MAX);
      queue_event(mctu_pkg::ACT_MOVE, 3, COORD_MIN, COORD_MAX, COORD_MIN);
      queue_event(mctu_pkg::ACT_UP, 3, COORD_MAX, COORD_MAX, COORD_MAX);
      // first point sets the origin, then a duplicate down
      queue_event(mctu_pkg::ACT_DOWN, 0, '0, '0, '0);
      queue_event(mctu_pkg::ACT_DOWN, 0, COORD_MAX, COORD_MAX, COORD_MAX);
      // each round pushes shift up and origin down by a full swing until both saturate
      for (int n = 0; n < 5; n++) begin
         queue_event(mctu_pkg::ACT_DOWN, 1, COORD_MAX, COORD_MAX, COORD_MAX);
         queue_event(mctu_pkg::ACT_MOVE, 1, COORD_MIN, COORD_MIN, COORD_MIN);
         queue_event(mctu_pkg::ACT_UP, 1, COORD_MAX, COORD_MIN, '0);
      end
      // mixed extremes per axis, up uses the stored position
      queue_event(mctu_pkg::ACT_DOWN, 15, COORD_MIN, COORD_MAX, mctu_pkg::coord_type'(-1));
      queue_event(mctu_pkg::ACT_MOVE, 15, COORD_MAX, COORD_MIN, '0);
      queue_event(mctu_pkg::ACT_UP, 15, '0, '0, '0);
      // last up clears everything, then a bad action on a cleared tracker
      queue_event(mctu_pkg::ACT_UP, 0, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_event(mctu_pkg::ACT_BAD, 0, '0, '0, '0);
      directed_events = pending_events.size();

      // random: mostly well-formed gestures, some noise, now and then all fingers lift
      random_count = 0;
      while (random_count < RANDOM_EVENTS) begin
         if (gen_count > 0 && $urandom_range(0, 59) == 0) begin
            for (int i = 0; i < mctu_pkg::MAX_TOUCHES; i++) begin
               if (gen_down[i]) begin
                  queue_event(mctu_pkg::ACT_UP, i, rand_coord(), rand_coord(), rand_coord());
                  random_count++;
               end
            end
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               queue_event(mctu_pkg::action_type'($urandom_range(0, 3)),
                           $urandom_range(0, 15),
                           rand_coord(), rand_coord(), rand_coord());
            end else begin
               // fewer downs as the panel fills up
               down_pct = (gen_count < 12) ? 35 : 10;
               up_pct   = (gen_count < 12) ? 20 : 40;
               roll = $urandom_range(0, 99);
               if (gen_count == 0)
                  act = mctu_pkg::ACT_DOWN;
               else if (gen_count < mctu_pkg::MAX_TOUCHES && roll < down_pct)
                  act = mctu_pkg::ACT_DOWN;
               else if (roll < down_pct + up_pct)
                  act = mctu_pkg::ACT_UP;
               else
                  act = mctu_pkg::ACT_MOVE;
               pick = $urandom_range(0, mctu_pkg::MAX_TOUCHES - 1);
               if (act == mctu_pkg::ACT_DOWN) begin
                  while (gen_down[pick]) pick = $urandom_range(0, mctu_pkg::MAX_TOUCHES - 1);
               end else begin
                  while (!gen_down[pick]) pick = $urandom_range(0, mctu_pkg::MAX_TOUCHES - 1);
               end
               queue_event(act, pick, rand_coord(), rand_coord(), rand_coord());
            end
            random_count++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every result back
      do
         @(negedge clock);
      while (pending_events.size() != 0 || req_bus.valid || centroid_expected.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && centroid_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/mctu_pkg.sv
src/mctu_req_if.sv
src/mctu_rsp_if.sv
src/mctu_store.sv
src/mctu_div.sv
src/multitouch_centroid_tracker_unit.sv
src/mctu_checker.sv
bench/testbench.sv
